>>> src/adpa_pkg.sv
`default_nettype none
package adpa_pkg;

  // Ring geometry; depth must be a power of two (mean is a shift)
  localparam int RING_DEPTH = 16;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int MEM_AW     = RING_AW + 1;
  localparam int MEM_DEPTH  = 2 * RING_DEPTH;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = SAMPLE_W + RING_AW;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP = 1'd1;
  localparam logic [7:0] CLOCK_RESET = 8'd13;
  localparam logic [7:0] SETUP_RESET = 8'h44;

  // Converter command bytes
  localparam logic [5:0] DATA_CMD_BASE  = 6'h38;
  localparam logic [5:0] CLOCK_CMD_BASE = 6'h20;
  localparam logic [4:0] SETUP_CMD_BASE = 5'h10;

  typedef struct packed {
    logic [7:0]          status_byte;
    logic [SAMPLE_W-1:0] sample;
  } poll_word_t;

  typedef struct packed {
    logic                accepted;
    logic                sample_channel;
    logic [5:0]          data_cmd;
    logic [SAMPLE_W-1:0] avg_ch0;
    logic [SAMPLE_W-1:0] avg_ch1;
    logic                avg_updated;
    logic                next_channel;
    logic [5:0]          clock_reg_cmd;
    logic [7:0]          clock_value;
    logic [4:0]          setup_reg_cmd;
    logic [7:0]          setup_value;
  } result_word_t;

  // Averager status toward the sequencer
  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] avg0;
    logic [SAMPLE_W-1:0] avg1;
  } avg_status_t;

endpackage
`default_nettype wire

>>> src/adpa_ring_mem.sv
`default_nettype none
module adpa_ring_mem
  import adpa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                we,
  input  wire logic [MEM_AW-1:0]   waddr,
  input  wire logic [SAMPLE_W-1:0] wdata,
  input  wire logic [RING_AW-1:0]  raddr,
  output      logic [SAMPLE_W-1:0] rdata0,
  output      logic [SAMPLE_W-1:0] rdata1
);

  // Both rings in one array: address = {channel, slot}
  logic [SAMPLE_W-1:0]  mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Unwritten entries read as the reset value (zero)
  always_ff @(posedge clk) begin
    rdata0 <= valid[{1'b0, raddr}] ? mem[{1'b0, raddr}] : '0;
    rdata1 <= valid[{1'b1, raddr}] ? mem[{1'b1, raddr}] : '0;
  end

endmodule
`default_nettype wire

>>> src/adpa_avg_unit.sv
`default_nettype none
module adpa_avg_unit
  import adpa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [SAMPLE_W-1:0] rdata0,
  input  wire logic [SAMPLE_W-1:0] rdata1,
  output      logic [RING_AW-1:0]  raddr,
  output      avg_status_t         status
);

  localparam logic [RING_AW-1:0] IDX_LAST = RING_AW'(RING_DEPTH - 1);

  logic                busy;
  logic [RING_AW-1:0]  idx;
  logic                rd_v;
  logic                rd_last;
  logic [SUM_W-1:0]    sum0;
  logic [SUM_W-1:0]    sum1;
  logic [SUM_W-1:0]    sum0_next;
  logic [SUM_W-1:0]    sum1_next;
  logic                done;
  logic [SAMPLE_W-1:0] avg0;
  logic [SAMPLE_W-1:0] avg1;

  assign raddr     = idx;
  assign sum0_next = sum0 + SUM_W'(rdata0);
  assign sum1_next = sum1 + SUM_W'(rdata1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      idx     <= '0;
      rd_v    <= 1'b0;
      rd_last <= 1'b0;
      done    <= 1'b0;
      avg0    <= '0;
      avg1    <= '0;
    end else begin
      done    <= 1'b0;
      // read data comes from a registered memory port, so it trails the address
      rd_v    <= busy;
      rd_last <= busy && (idx == IDX_LAST);
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 1'b1;
        if (idx == IDX_LAST) begin
          busy <= 1'b0;
        end
      end
      if (rd_last) begin
        avg0 <= sum0_next[RING_AW +: SAMPLE_W];
        avg1 <= sum1_next[RING_AW +: SAMPLE_W];
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum0 <= '0;
      sum1 <= '0;
    end else if (rd_v) begin
      sum0 <= sum0_next;
      sum1 <= sum1_next;
    end
  end

  assign status.done = done;
  assign status.avg0 = avg0;
  assign status.avg1 = avg1;

endmodule
`default_nettype wire

>>> src/dual_channel_adc_poll_average_top.sv
`default_nettype none
// Channel   Handshake                 Word
// poll      poll_valid / poll_stall   poll_word_t   (status_byte, sample)
// result    result_valid / result_stall result_word_t (averages, command bytes)
// config    cfg_we, cfg_index         cfg_data      (clock_setting, setup_setting)
//
// One poll word at a time. Not-ready polls and stores without an average
// update go straight to the emit state, and the next poll word can be taken
// once the result word is loaded into the output register. A store that
// triggers an update first runs a 16-address sweep of the ring memory (both
// rings read in parallel), then emits its result word.
// Reset (rst, synchronous) clears channel, slot, averages, settings and the
// ring valid bits. A result waiting under result_stall does not block the
// next poll word; the block holds a finished result until the register frees.
module dual_channel_adc_poll_average_top
  import adpa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  poll_valid,
  output      logic                  poll_stall,
  input  wire poll_word_t            poll_word,
  output      logic                  result_valid,
  input  wire logic                  result_stall,
  output      result_word_t          result_word,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [RING_AW-1:0] SLOT_LAST = RING_AW'(RING_DEPTH - 1);

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic               cur_ch;
  logic [RING_AW-1:0] slot;
  logic [7:0]         clock_setting;
  logic [7:0]         setup_setting;

  // per-item result info, held until the output register frees
  logic res_acc;
  logic res_ch;
  logic res_nxt;
  logic res_upd;

  logic               poll_take;
  logic               ready;
  logic [RING_AW-1:0] slot_inc;
  logic               update;
  logic               out_free;

  logic [SAMPLE_W-1:0] rdata0;
  logic [SAMPLE_W-1:0] rdata1;
  logic [RING_AW-1:0]  raddr;
  avg_status_t         avg_st;

  assign poll_stall = (state != ST_IDLE);
  assign poll_take  = poll_valid && !poll_stall;
  assign ready      = !poll_word.status_byte[0];
  assign slot_inc   = (slot == SLOT_LAST) ? '0 : slot + 1'b1;
  // averages refresh after a channel-1 store that lands on an odd slot (the advanced slot is even)
  assign update     = ready && cur_ch && !slot_inc[0];
  assign out_free   = !result_valid || !result_stall;

  // Write lands at the accept edge that starts the sweep; memory reads are
  // registered after it, so the new sample is visible to the sum (no bypass).
  adpa_ring_mem u_mem (
    .clk    (clk),
    .rst    (rst),
    .we     (poll_take && ready),
    .waddr  ({cur_ch, slot}),
    .wdata  (poll_word.sample),
    .raddr  (raddr),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  adpa_avg_unit u_avg (
    .clk    (clk),
    .rst    (rst),
    .start  (poll_take && update),
    .rdata0 (rdata0),
    .rdata1 (rdata1),
    .raddr  (raddr),
    .status (avg_st)
  );

  // config decode
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_setting <= CLOCK_RESET;
      setup_setting <= SETUP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLOCK: clock_setting <= cfg_data;
        REG_SETUP: setup_setting <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (poll_take) begin
          state_next = update ? ST_SUM : ST_EMIT;
        end
      end
      ST_SUM: begin
        if (avg_st.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cur_ch <= 1'b0;
      slot   <= '0;
    end else begin
      state <= state_next;
      if (poll_take && ready) begin
        cur_ch <= !cur_ch;
        if (cur_ch) begin
          slot <= slot_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (poll_take) begin
      res_acc <= ready;
      res_ch  <= cur_ch;
      res_nxt <= ready ? !cur_ch : cur_ch;
      res_upd <= update;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      result_word.accepted       <= res_acc;
      result_word.sample_channel <= res_ch;
      result_word.data_cmd       <= DATA_CMD_BASE + 6'(res_ch);
      result_word.avg_ch0        <= avg_st.avg0;
      result_word.avg_ch1        <= avg_st.avg1;
      result_word.avg_updated    <= res_upd;
      result_word.next_channel   <= res_nxt;
      result_word.clock_reg_cmd  <= CLOCK_CMD_BASE + 6'(res_nxt);
      result_word.clock_value    <= clock_setting;
      result_word.setup_reg_cmd  <= SETUP_CMD_BASE + 5'(res_nxt);
      result_word.setup_value    <= setup_setting;
    end
  end

  // after a poll word is taken, the next is held off until its result is registered
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    poll_take |=> poll_stall)
    else $error("poll word accepted while another is in flight");

  a_done_in_sum: assert property (@(posedge clk) disable iff (rst)
    avg_st.done |-> (state == ST_SUM))
    else $error("averager finished outside the sum phase");

  a_upd_on_ch1: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result_word.avg_updated
                      || (result_word.accepted && result_word.sample_channel)))
    else $error("average update without a stored channel-1 sample");

  a_ch_toggle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_word.accepted)
      |-> (result_word.next_channel != result_word.sample_channel))
    else $error("channel did not alternate after a stored sample");

endmodule
`default_nettype wire

>>> bench/adpa_result_checker.sv
`timescale 1ns / 100ps
// Watches the poll, result and config ports, predicts each result word and
// compares it field by field in arrival order.
module adpa_result_checker
  import adpa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  poll_valid,
  input  wire logic                  poll_stall,
  input  wire poll_word_t            poll_word,
  input  wire logic                  result_valid,
  input  wire logic                  result_stall,
  input  wire result_word_t          result_word,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         mismatches,
  output int                         outstanding
);

  result_word_t        expected_results[$];
  logic                cur_channel;
  logic [RING_AW-1:0]  slot;
  logic [SAMPLE_W-1:0] ring0 [RING_DEPTH];
  logic [SAMPLE_W-1:0] ring1 [RING_DEPTH];
  logic [SAMPLE_W-1:0] avg0;
  logic [SAMPLE_W-1:0] avg1;
  logic [7:0]          clock_setting;
  logic [7:0]          setup_setting;

  task automatic compute_poll_result(input poll_word_t w, output result_word_t r);
    logic             ch;
    logic             upd;
    logic [SUM_W-1:0] sum0;
    logic [SUM_W-1:0] sum1;
    begin
      ch  = cur_channel;
      upd = 1'b0;
      if (!w.status_byte[0]) begin
        if (!ch) begin
          ring0[slot] = w.sample;
          cur_channel = 1'b1;
        end else begin
          ring1[slot] = w.sample;
          cur_channel = 1'b0;
          slot = slot + 1'b1;
          // averages refresh on every even slot after a channel-1 store
          if (!slot[0]) begin
            sum0 = '0;
            sum1 = '0;
            for (int k = 0; k < RING_DEPTH; k++) begin
              sum0 = sum0 + SUM_W'(ring0[k]);
              sum1 = sum1 + SUM_W'(ring1[k]);
            end
            avg0 = sum0[SUM_W-1:RING_AW];
            avg1 = sum1[SUM_W-1:RING_AW];
            upd  = 1'b1;
          end
        end
      end
      r.accepted       = !w.status_byte[0];
      r.sample_channel = ch;
      r.data_cmd       = DATA_CMD_BASE + 6'(ch);
      r.avg_ch0        = avg0;
      r.avg_ch1        = avg1;
      r.avg_updated    = upd;
      r.next_channel   = cur_channel;
      r.clock_reg_cmd  = CLOCK_CMD_BASE + 6'(cur_channel);
      r.clock_value    = clock_setting;
      r.setup_reg_cmd  = SETUP_CMD_BASE + 5'(cur_channel);
      r.setup_value    = setup_setting;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_word_t exp_w;
    result_word_t new_w;
    if (rst) begin
      cur_channel   = 1'b0;
      slot          = '0;
      avg0          = '0;
      avg1          = '0;
      clock_setting = CLOCK_RESET;
      setup_setting = SETUP_RESET;
      for (int k = 0; k < RING_DEPTH; k++) begin
        ring0[k] = '0;
        ring1[k] = '0;
      end
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CLOCK) clock_setting = cfg_data;
        else if (cfg_index == REG_SETUP) setup_setting = cfg_data;
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual %h",
                   $time, result_word);
          mismatches++;
        end else begin
          exp_w = expected_results.pop_front();
          check_field("accepted", 32'(exp_w.accepted), 32'(result_word.accepted));
          check_field("sample_channel", 32'(exp_w.sample_channel),
                      32'(result_word.sample_channel));
          check_field("data_cmd", 32'(exp_w.data_cmd), 32'(result_word.data_cmd));
          check_field("avg_ch0", 32'(exp_w.avg_ch0), 32'(result_word.avg_ch0));
          check_field("avg_ch1", 32'(exp_w.avg_ch1), 32'(result_word.avg_ch1));
          check_field("avg_updated", 32'(exp_w.avg_updated),
                      32'(result_word.avg_updated));
          check_field("next_channel", 32'(exp_w.next_channel),
                      32'(result_word.next_channel));
          check_field("clock_reg_cmd", 32'(exp_w.clock_reg_cmd),
                      32'(result_word.clock_reg_cmd));
          check_field("clock_value", 32'(exp_w.clock_value),
                      32'(result_word.clock_value));
          check_field("setup_reg_cmd", 32'(exp_w.setup_reg_cmd),
                      32'(result_word.setup_reg_cmd));
          check_field("setup_value", 32'(exp_w.setup_value),
                      32'(result_word.setup_value));
        end
      end
      if (poll_valid && !poll_stall) begin
        compute_poll_result(poll_word, new_w);
        expected_results.push_back(new_w);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

>>> bench/tb_dual_channel_adc_poll_average_top.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the two-channel poll averager. The checker beside
// the block does all prediction; this module only drives words and decides.
module tb_dual_channel_adc_poll_average_top;
  import adpa_pkg::*;

  // quiet cycles allowed: the update sweep plus stall and gap runs,
  // taken many times over
  localparam int QUIET_LIMIT = 2000;
  localparam int END_HOLD    = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  poll_valid = 1'b0;
  logic                  poll_stall;
  poll_word_t            poll_word = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_word_t          result_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_CLOCK;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;

  // idle controls for the two sides
  bit poll_gaps_on   = 1'b1;
  bit result_stall_on = 1'b1;

  always #1 clk = ~clk;

  dual_channel_adc_poll_average_top dut (
    .clk          (clk),
    .rst          (rst),
    .poll_valid   (poll_valid),
    .poll_stall   (poll_stall),
    .poll_word    (poll_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  adpa_result_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .poll_valid   (poll_valid),
    .poll_stall   (poll_stall),
    .poll_word    (poll_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // receiver backpressure, independent of result_valid
  always @(negedge clk) begin
    result_stall <= result_stall_on && ($urandom_range(0, 99) < 25);
  end

  // watchdog: any accepted word on either channel resets the count
  always @(posedge clk) begin
    if (rst || (poll_valid && !poll_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one poll word and hold it until taken. Called and left at a falling
  // edge; poll_valid stays high on exit so back-to-back words never drop it.
  task automatic send_poll(input poll_word_t w);
    while (poll_gaps_on && ($urandom_range(0, 99) < 25)) begin
      poll_valid <= 1'b0;
      @(negedge clk);
    end
    poll_valid <= 1'b1;
    poll_word  <= w;
    @(posedge clk);
    while (poll_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender holds off until every predicted result word has come back.
  task automatic wait_drained();
    poll_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Both registers, back to back; only called with the block idle.
  task automatic set_settings(input logic [7:0] clock_v, input logic [7:0] setup_v);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CLOCK;
    cfg_data  <= clock_v;
    @(negedge clk);
    cfg_index <= REG_SETUP;
    cfg_data  <= setup_v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly ready polls; status bits above bit 0 are pure noise.
  function automatic poll_word_t random_poll(input int mode);
    poll_word_t w;
    w.status_byte    = 8'($urandom);
    w.status_byte[0] = ($urandom_range(0, 99) >= 80);
    case (mode)
      1:       w.sample = 16'hFFFF;
      2:       w.sample = 16'h0000;
      default: w.sample = 16'($urandom);
    endcase
    return w;
  endfunction

  // Runs of a fixed sample flavor so the averages also reach full scale
  // and zero, not just mid-range noise.
  task automatic run_random(input int n_items);
    int sent;
    int mode;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      mode    = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 2);
      run_len = $urandom_range(8, 48);
      for (int i = 0; i < run_len && sent < n_items; i++) begin
        send_poll(random_poll(mode));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset settings: ready on each channel, not-ready with only
    // bit 0 and with all bits set, ready with every other status bit set,
    // and the first channel-1 store landing on an odd slot (average update).
    send_poll(poll_word_t'{8'h00, 16'hFFFF});
    send_poll(poll_word_t'{8'h01, 16'h1234});
    send_poll(poll_word_t'{8'h00, 16'hFFFF});
    send_poll(poll_word_t'{8'hFE, 16'h0000});
    send_poll(poll_word_t'{8'hFF, 16'hFFFF});
    send_poll(poll_word_t'{8'h80, 16'hFFFF});
    wait_drained();

    // Directed, settings at the low/high extremes: full-scale then zero
    // samples, alternating status noise, one not-ready in the middle.
    set_settings(8'h00, 8'hFF);
    for (int i = 0; i < 16; i++) begin
      send_poll(poll_word_t'{(i % 2) ? 8'hFE : 8'h00, (i < 8) ? 16'hFFFF : 16'h0000});
      if (i == 7) send_poll(poll_word_t'{8'h01, 16'hFFFF});
    end
    wait_drained();

    // Random, settings swapped to the opposite extremes, both sides idling.
    set_settings(8'hFF, 8'h00);
    run_random(350);
    wait_drained();

    // Random, long stretch with no idling on either side.
    poll_gaps_on    = 1'b0;
    result_stall_on = 1'b0;
    set_settings(8'($urandom), 8'($urandom));
    run_random(350);
    wait_drained();

    // Random, idling back on, fresh settings.
    poll_gaps_on    = 1'b1;
    result_stall_on = 1'b1;
    set_settings(8'($urandom), 8'($urandom));
    run_random(400);
    wait_drained();

    repeat (END_HOLD) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
